// ===== src/lcdseq_pkg.sv =====
`default_nettype none
package lcdseq_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_FOUR_BIT_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_HIGH_TICKS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_LOW_TICKS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_UP_TICKS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_WAIT_TICKS  = 3'd4;

   localparam logic        RST_FOUR_BIT_MODE     = 1'b1;
   localparam logic [15:0] RST_ENABLE_HIGH_TICKS = 16'd1000;
   localparam logic [15:0] RST_ENABLE_LOW_TICKS  = 16'd1000;
   localparam logic [19:0] RST_POWER_UP_TICKS    = 20'd50000;
   localparam logic [15:0] RST_CLEAR_WAIT_TICKS  = 16'd2000;

   // stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // LCD instruction codes
   localparam logic [7:0] LCD_FUNC_4BIT_INIT = 8'h02;
   localparam logic [7:0] LCD_FUNC_4BIT_2L   = 8'h28;
   localparam logic [7:0] LCD_FUNC_8BIT_2L   = 8'h38;
   localparam logic [7:0] LCD_DISPLAY_ON     = 8'h0C;
   localparam logic [7:0] LCD_CLR_DISPLAY    = 8'h01;
   localparam logic [7:0] LCD_ENTRY_MODE     = 8'h06;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_INSTR  = 2'd1,
      KIND_DATA   = 2'd2,
      KIND_CURSOR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_POWER   = 3'd0,
      PH_EN_HIGH = 3'd1,
      PH_EN_LOW  = 3'd2,
      PH_CLEAR   = 3'd3,
      PH_IDLE    = 3'd4
   } phase_type;

   typedef struct packed {
      logic        four_bit_mode;
      logic [15:0] enable_high_ticks;
      logic [15:0] enable_low_ticks;
      logic [19:0] power_up_ticks;
      logic [15:0] clear_wait_ticks;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_value;
      logic       line;
      logic [5:0] cell_req;
   } item_type;

   typedef struct packed {
      logic       rs_pin;
      logic       en_pin;
      logic [7:0] data_pins;
      logic       busy_res;
      logic       accepted;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] word;
   } init_word_type;

   // init word table; valid low past the end of the list for the mode
   function automatic init_word_type init_lookup(input logic four, input logic [2:0] idx);
      init_word_type r;
      r.valid = 1'b1;
      r.word  = 8'h00;
      if (four) begin
         unique case (idx)
            3'd0:    r.word = LCD_FUNC_4BIT_INIT;
            3'd1:    r.word = LCD_FUNC_4BIT_2L;
            3'd2:    r.word = LCD_DISPLAY_ON;
            3'd3:    r.word = LCD_CLR_DISPLAY;
            3'd4:    r.word = LCD_ENTRY_MODE;
            default: r.valid = 1'b0;
         endcase
      end else begin
         unique case (idx)
            3'd0:    r.word = LCD_FUNC_8BIT_2L;
            3'd1:    r.word = LCD_DISPLAY_ON;
            3'd2:    r.word = LCD_CLR_DISPLAY;
            3'd3:    r.word = LCD_ENTRY_MODE;
            default: r.valid = 1'b0;
         endcase
      end
      return r;
   endfunction

   // busy phases; unused codes count as idle
   function automatic logic phase_active(input phase_type ph);
      return (ph == PH_POWER) || (ph == PH_EN_HIGH) || (ph == PH_EN_LOW) || (ph == PH_CLEAR);
   endfunction

endpackage
`default_nettype wire

// ===== src/char_lcd_bus_sequencer.sv =====
`default_nettype none
// Data path: a word taken on req_ passes the input register, then the sequencer step
//   into the result register, before it shows up on rsp_.
// Throughput: one word per cycle while the result side does not stall; set by the
//   single-step sequencer between the input register and the result register.
// Reset: synchronous, active high; control registers return to their reset values (the data
//   registers keep their contents) and the sequencer restarts with the power-up wait.
module char_lcd_bus_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [lcdseq_pkg::REQ_DATA_W-1:0]   req_tdata,  // byte_value[7:0], line[8], cell_req[14:9]
   input  wire logic [1:0]                          req_tuser,  // kind[1:0]
   // result channel
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [lcdseq_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // rs_pin[0], en_pin[1],
                                                                // data_pins[9:2], busy_res[10],
                                                                // accepted[11]
   // configuration write port
   input  wire logic                                csr_we,
   input  wire logic [lcdseq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lcdseq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lcdseq_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff;
   result_type result;
   result_type out_ff;
   logic       out_valid_ff;
   logic       advance;

   lcdseq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stage 1: input register. It moves on whenever the result register is
   // empty or being drained, so a new word is taken every cycle under flow.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      item_in.kind       = kind_type'(req_tuser);
      item_in.byte_value = req_tdata[7:0];
      item_in.line       = req_tdata[8];
      item_in.cell_req   = req_tdata[14:9];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   // stage 2: one sequencer step per word; state commits only on advance
   lcdseq_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.accepted, out_ff.busy_res, out_ff.data_pins,
                        out_ff.en_pin, out_ff.rs_pin};

   // a taken request always starts a transfer, so the block reports busy
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.accepted) |-> out_ff.busy_res)
      else $error("accepted request without busy");

   // enable is only driven during a transfer
   a_enable_busy : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.en_pin) |-> out_ff.busy_res)
      else $error("enable high while idle");

   // a held input word is not dropped while the result side stalls
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input word lost under stall");

   // a result waiting on a stall is not overwritten
   a_hold_output : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("result changed under stall");

endmodule
`default_nettype wire

// ===== src/lcdseq_csr.sv =====
`default_nettype none
module lcdseq_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [lcdseq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lcdseq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output      lcdseq_pkg::cfg_type                cfg
);
   import lcdseq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FOUR_BIT_MODE:     cfg_in.four_bit_mode     = csr_wdata[0];
            CSR_ENABLE_HIGH_TICKS: cfg_in.enable_high_ticks = csr_wdata[15:0];
            CSR_ENABLE_LOW_TICKS:  cfg_in.enable_low_ticks  = csr_wdata[15:0];
            CSR_POWER_UP_TICKS:    cfg_in.power_up_ticks    = csr_wdata[19:0];
            CSR_CLEAR_WAIT_TICKS:  cfg_in.clear_wait_ticks  = csr_wdata[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.four_bit_mode     <= RST_FOUR_BIT_MODE;
         cfg_ff.enable_high_ticks <= RST_ENABLE_HIGH_TICKS;
         cfg_ff.enable_low_ticks  <= RST_ENABLE_LOW_TICKS;
         cfg_ff.power_up_ticks    <= RST_POWER_UP_TICKS;
         cfg_ff.clear_wait_ticks  <= RST_CLEAR_WAIT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== src/lcdseq_engine.sv =====
`default_nettype none
module lcdseq_engine (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  lcdseq_pkg::item_type   item,
   input  lcdseq_pkg::cfg_type    cfg,
   output lcdseq_pkg::result_type result
);
   import lcdseq_pkg::*;

   phase_type   phase_ff,  phase_in;
   logic [19:0] wait_ff,   wait_in;
   logic [7:0]  shift_ff,  shift_in;
   logic        sel_ff,    sel_in;
   logic        second_ff, second_in;
   logic [2:0]  index_ff,  index_in;
   logic        done_ff,   done_in;
   logic        acc;

   logic          idle_now;
   logic          idle_next;
   logic          do_load;
   logic          finish;
   logic [2:0]    load_idx;
   init_word_type lookup;
   logic [15:0]   high_min;
   logic [15:0]   low_min;

   assign idle_now = done_ff && !phase_active(phase_ff);
   // a zero pulse time acts as one tick
   assign high_min = (cfg.enable_high_ticks == 16'd0) ? 16'd1 : cfg.enable_high_ticks;
   assign low_min  = (cfg.enable_low_ticks  == 16'd0) ? 16'd1 : cfg.enable_low_ticks;

   always_comb begin : next_state
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      shift_in  = shift_ff;
      sel_in    = sel_ff;
      second_in = second_ff;
      index_in  = index_ff;
      done_in   = done_ff;
      acc       = 1'b0;
      do_load   = 1'b0;
      finish    = 1'b0;
      load_idx  = index_ff;

      if ((item.kind != KIND_TICK) && idle_now) begin
         acc       = 1'b1;
         second_in = 1'b0;
         phase_in  = PH_EN_HIGH;
         wait_in   = 20'd1;
         unique case (item.kind)
            KIND_INSTR: begin
               shift_in = item.byte_value;
               sel_in   = 1'b0;
            end
            KIND_DATA: begin
               shift_in = item.byte_value;
               sel_in   = 1'b1;
            end
            KIND_CURSOR: begin
               shift_in = {1'b1, item.line, item.cell_req};
               sel_in   = 1'b0;
            end
            KIND_TICK: begin
               shift_in = shift_ff;
            end
         endcase
      end else begin
         unique case (phase_ff)
            PH_POWER: begin
               if (wait_ff >= cfg.power_up_ticks) begin
                  do_load = 1'b1;
               end else begin
                  wait_in = wait_ff + 20'd1;
               end
            end
            PH_EN_HIGH: begin
               if (wait_ff >= {4'd0, high_min}) begin
                  phase_in = PH_EN_LOW;
                  wait_in  = 20'd1;
               end else begin
                  wait_in = wait_ff + 20'd1;
               end
            end
            PH_EN_LOW: begin
               if (wait_ff >= {4'd0, low_min}) begin
                  if (cfg.four_bit_mode && !second_ff) begin
                     second_in = 1'b1;
                     phase_in  = PH_EN_HIGH;
                     wait_in   = 20'd1;
                  end else if (!sel_ff && (shift_ff == LCD_CLR_DISPLAY) &&
                               (cfg.clear_wait_ticks != 16'd0)) begin
                     phase_in = PH_CLEAR;
                     wait_in  = 20'd1;
                  end else begin
                     finish = 1'b1;
                  end
               end else begin
                  wait_in = wait_ff + 20'd1;
               end
            end
            PH_CLEAR: begin
               if (wait_ff >= {4'd0, cfg.clear_wait_ticks}) begin
                  finish = 1'b1;
               end else begin
                  wait_in = wait_ff + 20'd1;
               end
            end
            default: begin
               if (!done_ff) begin
                  do_load = 1'b1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         endcase

         // end of a byte: next init word, or back to idle
         if (finish) begin
            if (done_ff) begin
               phase_in = PH_IDLE;
            end else begin
               load_idx = index_ff + 3'd1;
               index_in = load_idx;
               do_load  = 1'b1;
            end
         end
      end

      lookup = init_lookup(cfg.four_bit_mode, load_idx);
      if (do_load) begin
         if (!lookup.valid) begin
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end else begin
            shift_in  = lookup.word;
            sel_in    = 1'b0;
            second_in = 1'b0;
            phase_in  = PH_EN_HIGH;
            wait_in   = 20'd1;
         end
      end
   end

   always_comb begin : outputs
      idle_next        = done_in && !phase_active(phase_in);
      result.rs_pin    = sel_in;
      result.en_pin    = (phase_in == PH_EN_HIGH);
      result.busy_res  = !idle_next;
      result.accepted  = acc;
      if (cfg.four_bit_mode) begin
         result.data_pins = second_in ? {shift_in[3:0], 4'd0} : {shift_in[7:4], 4'd0};
      end else begin
         result.data_pins = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_POWER;
         wait_ff   <= '0;
         shift_ff  <= '0;
         sel_ff    <= 1'b0;
         second_ff <= 1'b0;
         index_ff  <= '0;
         done_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         wait_ff   <= wait_in;
         shift_ff  <= shift_in;
         sel_ff    <= sel_in;
         second_ff <= second_in;
         index_ff  <= index_in;
         done_ff   <= done_in;
      end
   end

endmodule
`default_nettype wire
